// ----- src/i2cms_pkg.sv -----
// Shared types and bus command codes for the I2C master transaction sequencer.
package i2cms_pkg;

    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_EVENT  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_RESTART   = 3'd2;
    localparam logic [2:0] CMD_SEND      = 3'd3;
    localparam logic [2:0] CMD_RECV_ACK  = 3'd4;
    localparam logic [2:0] CMD_RECV_NACK = 3'd5;
    localparam logic [2:0] CMD_STOP      = 3'd6;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ADDR_NACK   = 2'd1;
    localparam logic [1:0] STATUS_READDR_NACK = 2'd2;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] bus_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_read;
        logic       done_res;
        logic [1:0] status;
    } result_t;

    // Results raised by one input item: one or two, first in slot 0
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } result_pair_t;

endpackage

// ----- src/i2cms_out_queue.sv -----
// Output queue that holds result pairs and hands them out one beat at a time.
module i2cms_out_queue
    import i2cms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_pair_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output result_t      head
);

    localparam int QDEPTH = 2;

    result_pair_t     entry_reg [QDEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             sub_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             beat;
    logic             pop;
    result_pair_t     head_pair;

    assign head_pair = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(QDEPTH));
    assign head      = sub_reg ? head_pair.second : head_pair.first;
    assign beat      = out_valid && !out_stall;
    // Drop the pair once its last result has gone out
    assign pop       = beat && (sub_reg || !head_pair.two);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sub_reg    <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                sub_reg    <= 1'b0;
            end
            else if (beat)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full result queue");

    a_sub_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (out_valid && head_pair.two))
        else $error("second slot selected on a single-result entry");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("result queue count out of range");

endmodule

// ----- src/i2c_master_transaction_sequencer.sv -----
// Top level of the byte-level I2C master write/read sequencer with repeated start.
// An accepted item's results are registered in the result queue, which drives the output.
// Throughput: one input beat per cycle while the two-pair result queue has room;
// an item raising two results (start and address, restart and address) hands them out
// as two output beats, so the output port can then limit the sustained rate.
// Reset: rst_n clears the phase, counts and result queue; the block comes up idle.
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
#(
    parameter int MAX_TRANSFER = 255
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [6:0] device_address,
    input  logic [7:0] write_count,
    input  logic [7:0] read_count,
    input  logic [7:0] data_byte,
    input  logic       ack_received,
    input  logic [7:0] received_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] bus_command,
    output logic [7:0] bus_byte,
    output logic [7:0] read_data,
    output logic       read_valid,
    output logic       last_read,
    output logic       done_res,
    output logic [1:0] status
);

    // Counts never exceed the smaller of the clamp limit and an 8-bit count
    localparam int CNT_W = (MAX_TRANSFER >= 255) ? 8 : $clog2(MAX_TRANSFER + 1);

    // Transaction phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_ADDR      = 3'd1;
    localparam logic [2:0] PH_NEED_DATA = 3'd2;
    localparam logic [2:0] PH_DATA_SENT = 3'd3;
    localparam logic [2:0] PH_READDR    = 3'd4;
    localparam logic [2:0] PH_READING   = 3'd5;

    logic [2:0]       phase_reg,       phase_next;
    logic [6:0]       target_reg,      target_next;
    logic [CNT_W-1:0] writes_left_reg, writes_left_next;
    logic [CNT_W-1:0] reads_left_reg,  reads_left_next;
    logic             read_dir_reg,    read_dir_next;

    logic             in_beat;
    logic             queue_full;
    logic             push;
    result_pair_t     pair;
    result_t          head;

    logic [CNT_W-1:0] wr_clamped;
    logic [CNT_W-1:0] rd_clamped;
    logic [CNT_W-1:0] writes_dec;
    logic [CNT_W-1:0] reads_dec;
    logic             begin_dir;

    // Hold input whenever the queue cannot take another pair
    assign in_stall = queue_full;
    assign in_beat  = in_valid && !in_stall;

    // Clamp the requested counts to the transfer limit
    assign wr_clamped = (32'(write_count) > MAX_TRANSFER) ? CNT_W'(MAX_TRANSFER)
                                                          : CNT_W'(write_count);
    assign rd_clamped = (32'(read_count) > MAX_TRANSFER) ? CNT_W'(MAX_TRANSFER)
                                                         : CNT_W'(read_count);
    assign begin_dir  = (wr_clamped == '0) && (rd_clamped != '0);

    // Saturating decrements, as a byte that ends a count never goes below zero
    assign writes_dec = (writes_left_reg != '0) ? writes_left_reg - CNT_W'(1) : '0;
    assign reads_dec  = (reads_left_reg  != '0) ? reads_left_reg  - CNT_W'(1) : '0;

    function automatic result_t make_result(input logic [2:0] cmd,
                                            input logic [7:0] byte_val);
        result_t r;
        r             = '0;
        r.bus_command = cmd;
        r.bus_byte    = byte_val;
        return r;
    endfunction

    function automatic result_t make_stop(input logic [1:0] stat);
        result_t r;
        r             = '0;
        r.bus_command = CMD_STOP;
        r.done_res    = 1'b1;
        r.status      = stat;
        return r;
    endfunction

    always_comb
    begin
        phase_next       = phase_reg;
        target_next      = target_reg;
        writes_left_next = writes_left_reg;
        reads_left_next  = reads_left_reg;
        read_dir_next    = read_dir_reg;
        push             = 1'b0;
        pair             = '0;

        case (action)
            ACT_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    target_next      = device_address;
                    writes_left_next = wr_clamped;
                    reads_left_next  = rd_clamped;
                    read_dir_next    = begin_dir;
                    phase_next       = PH_ADDR;
                    push             = 1'b1;
                    pair.two         = 1'b1;
                    pair.first       = make_result(CMD_START, 8'd0);
                    pair.second      = make_result(CMD_SEND, {device_address, begin_dir});
                end
            end
            ACT_DATA:
            begin
                if (phase_reg == PH_NEED_DATA)
                begin
                    phase_next = PH_DATA_SENT;
                    push       = 1'b1;
                    pair.first = make_result(CMD_SEND, data_byte);
                end
            end
            ACT_EVENT:
            begin
                case (phase_reg)
                    PH_ADDR:
                    begin
                        if (!ack_received)
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            pair.first = make_stop(STATUS_ADDR_NACK);
                        end
                        else if (writes_left_reg != '0)
                        begin
                            phase_next = PH_NEED_DATA;
                        end
                        else if (read_dir_reg)
                        begin
                            phase_next = PH_READING;
                            push       = 1'b1;
                            pair.first = make_result(
                                (reads_left_reg == CNT_W'(1)) ? CMD_RECV_NACK : CMD_RECV_ACK,
                                8'd0);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            pair.first = make_stop(STATUS_OK);
                        end
                    end
                    PH_DATA_SENT:
                    begin
                        writes_left_next = writes_dec;
                        if (writes_dec != '0)
                        begin
                            phase_next = PH_NEED_DATA;
                        end
                        else if (reads_left_reg != '0)
                        begin
                            phase_next  = PH_READDR;
                            push        = 1'b1;
                            pair.two    = 1'b1;
                            pair.first  = make_result(CMD_RESTART, 8'd0);
                            pair.second = make_result(CMD_SEND, {target_reg, 1'b1});
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            pair.first = make_stop(STATUS_OK);
                        end
                    end
                    PH_READDR:
                    begin
                        if (!ack_received)
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            pair.first = make_stop(STATUS_READDR_NACK);
                        end
                        else
                        begin
                            phase_next = PH_READING;
                            push       = 1'b1;
                            pair.first = make_result(
                                (reads_left_reg == CNT_W'(1)) ? CMD_RECV_NACK : CMD_RECV_ACK,
                                8'd0);
                        end
                    end
                    PH_READING:
                    begin
                        // Each completed receive carries its byte with the next command
                        reads_left_next = reads_dec;
                        push            = 1'b1;
                        if (reads_dec != '0)
                        begin
                            pair.first = make_result(
                                (reads_dec == CNT_W'(1)) ? CMD_RECV_NACK : CMD_RECV_ACK,
                                8'd0);
                        end
                        else
                        begin
                            phase_next          = PH_IDLE;
                            pair.first          = make_stop(STATUS_OK);
                            pair.first.last_read = 1'b1;
                        end
                        pair.first.read_data  = received_byte;
                        pair.first.read_valid = 1'b1;
                    end
                    default:
                    begin
                        // Events while idle or awaiting a data byte are dropped
                    end
                endcase
            end
            default:
            begin
                // Unused action code: drop the beat
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            target_reg      <= '0;
            writes_left_reg <= '0;
            reads_left_reg  <= '0;
            read_dir_reg    <= 1'b0;
        end
        else if (in_beat)
        begin
            phase_reg       <= phase_next;
            target_reg      <= target_next;
            writes_left_reg <= writes_left_next;
            reads_left_reg  <= reads_left_next;
            read_dir_reg    <= read_dir_next;
        end
    end

    i2cms_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_beat && push),
        .push_data (pair),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign bus_command = head.bus_command;
    assign bus_byte    = head.bus_byte;
    assign read_data   = head.read_data;
    assign read_valid  = head.read_valid;
    assign last_read   = head.last_read;
    assign done_res    = head.done_res;
    assign status      = head.status;

    a_begin_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (action == ACT_BEGIN) && (phase_reg == PH_IDLE))
            |=> (phase_reg == PH_ADDR))
        else $error("begin beat did not move the sequencer to the address phase");

    a_done_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (bus_command == CMD_STOP))
        else $error("done raised without a stop command");

    a_last_read_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_valid) |-> ((bus_command == CMD_STOP) == last_read))
        else $error("final read byte not paired with stop");

    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (status == STATUS_OK))
        else $error("status reported without done");

endmodule

// ----- tb/sv/i2c_master_transaction_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master transaction sequencer.
module i2c_master_transaction_sequencer_tb
    import i2cms_pkg::*;
();

    localparam int MAX_XFER = 255;

    // Where the sequencer stands between items
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ADDR,
        SEQ_NEED_DATA,
        SEQ_DATA_SENT,
        SEQ_READDR,
        SEQ_READING
    } seq_phase_t;

    // One input beat, field for field
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] device_address;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic [7:0] data_byte;
        logic       ack_received;
        logic [7:0] received_byte;
    } bus_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = ACT_UNUSED;
    logic [6:0] device_address = '0;
    logic [7:0] write_count = '0;
    logic [7:0] read_count = '0;
    logic [7:0] data_byte = '0;
    logic       ack_received = 1'b0;
    logic [7:0] received_byte = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] bus_command;
    logic [7:0] bus_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_read;
    logic       done_res;
    logic [1:0] status;

    // Predicted sequencer state
    seq_phase_t seq_phase = SEQ_IDLE;
    logic [6:0] seq_addr = '0;
    logic [7:0] seq_writes = '0;
    logic [7:0] seq_reads = '0;
    bit         seq_read_dir = 1'b0;

    // Bus command beats still owed by the block, oldest first
    result_t    beats_due[$];

    int         errors = 0;
    int         items_sent = 0;
    int         beats_checked = 0;
    int         transactions_begun = 0;

    // When set, neither side idles or stalls
    bit         quiet = 1'b0;
    int         stall_run = 0;
    bit         stall_hold = 1'b0;

    always #4 clk = ~clk;

    i2c_master_transaction_sequencer #(
        .MAX_TRANSFER(MAX_XFER)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .device_address(device_address),
        .write_count(write_count),
        .read_count(read_count),
        .data_byte(data_byte),
        .ack_received(ack_received),
        .received_byte(received_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bus_command(bus_command),
        .bus_byte(bus_byte),
        .read_data(read_data),
        .read_valid(read_valid),
        .last_read(last_read),
        .done_res(done_res),
        .status(status)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic result_t make_beat(logic [2:0] cmd, logic [7:0] bbyte,
                                          logic [7:0] rdata, logic rvalid,
                                          logic last, logic done, logic [1:0] st);
        result_t r;
        r.bus_command = cmd;
        r.bus_byte    = bbyte;
        r.read_data   = rdata;
        r.read_valid  = rvalid;
        r.last_read   = last;
        r.done_res    = done;
        r.status      = st;
        return r;
    endfunction

    function automatic logic [7:0] clamp_count(logic [7:0] v);
        return (int'(v) > MAX_XFER) ? 8'(MAX_XFER) : v;
    endfunction

    // NACK on the final byte, ACK on every other one
    function automatic logic [2:0] receive_command();
        return (seq_reads == 8'd1) ? CMD_RECV_NACK : CMD_RECV_ACK;
    endfunction

    task automatic close_transaction(logic [1:0] st);
        seq_phase = SEQ_IDLE;
        beats_due.push_back(make_beat(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, st));
    endtask

    // Advance the predicted sequencer by one accepted beat and queue what it owes
    task automatic advance_sequencer(bus_item_t it);
        case (it.action)
            ACT_BEGIN:
            begin
                // A begin while busy is dropped
                if (seq_phase == SEQ_IDLE)
                begin
                    seq_addr     = it.device_address;
                    seq_writes   = clamp_count(it.write_count);
                    seq_reads    = clamp_count(it.read_count);
                    seq_read_dir = (seq_writes == 8'd0) && (seq_reads != 8'd0);
                    seq_phase    = SEQ_ADDR;
                    transactions_begun++;
                    beats_due.push_back(make_beat(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0,
                                                  1'b0, STATUS_OK));
                    beats_due.push_back(make_beat(CMD_SEND, {seq_addr, seq_read_dir}, 8'h00,
                                                  1'b0, 1'b0, 1'b0, STATUS_OK));
                end
            end
            ACT_DATA:
            begin
                if (seq_phase == SEQ_NEED_DATA)
                begin
                    seq_phase = SEQ_DATA_SENT;
                    beats_due.push_back(make_beat(CMD_SEND, it.data_byte, 8'h00, 1'b0,
                                                  1'b0, 1'b0, STATUS_OK));
                end
            end
            ACT_EVENT:
            begin
                case (seq_phase)
                    SEQ_ADDR:
                    begin
                        if (!it.ack_received)
                            close_transaction(STATUS_ADDR_NACK);
                        else if (seq_writes != 8'd0)
                            seq_phase = SEQ_NEED_DATA;
                        else if (seq_read_dir)
                        begin
                            seq_phase = SEQ_READING;
                            beats_due.push_back(make_beat(receive_command(), 8'h00, 8'h00,
                                                          1'b0, 1'b0, 1'b0, STATUS_OK));
                        end
                        else
                            close_transaction(STATUS_OK);
                    end
                    SEQ_DATA_SENT:
                    begin
                        // The ACK of a data byte does not matter
                        if (seq_writes != 8'd0)
                            seq_writes--;
                        if (seq_writes != 8'd0)
                            seq_phase = SEQ_NEED_DATA;
                        else if (seq_reads != 8'd0)
                        begin
                            seq_phase = SEQ_READDR;
                            beats_due.push_back(make_beat(CMD_RESTART, 8'h00, 8'h00, 1'b0,
                                                          1'b0, 1'b0, STATUS_OK));
                            beats_due.push_back(make_beat(CMD_SEND, {seq_addr, 1'b1}, 8'h00,
                                                          1'b0, 1'b0, 1'b0, STATUS_OK));
                        end
                        else
                            close_transaction(STATUS_OK);
                    end
                    SEQ_READDR:
                    begin
                        if (!it.ack_received)
                            close_transaction(STATUS_READDR_NACK);
                        else
                        begin
                            seq_phase = SEQ_READING;
                            beats_due.push_back(make_beat(receive_command(), 8'h00, 8'h00,
                                                          1'b0, 1'b0, 1'b0, STATUS_OK));
                        end
                    end
                    SEQ_READING:
                    begin
                        // The received byte rides with the next command
                        if (seq_reads != 8'd0)
                            seq_reads--;
                        if (seq_reads != 8'd0)
                            beats_due.push_back(make_beat(receive_command(), 8'h00,
                                                          it.received_byte, 1'b1, 1'b0,
                                                          1'b0, STATUS_OK));
                        else
                        begin
                            seq_phase = SEQ_IDLE;
                            beats_due.push_back(make_beat(CMD_STOP, 8'h00, it.received_byte,
                                                          1'b1, 1'b1, 1'b1, STATUS_OK));
                        end
                    end
                    default:
                        ; // events while idle or awaiting data are dropped
                endcase
            end
            default:
                ; // unused action code
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare every accepted output beat with the oldest one owed
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (beats_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual command %0d",
                         $time, bus_command);
                errors++;
            end
            else
            begin
                want = beats_due.pop_front();
                check_field("bus_command", 8'(want.bus_command), 8'(bus_command));
                check_field("bus_byte", want.bus_byte, bus_byte);
                check_field("read_data", want.read_data, read_data);
                check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
                check_field("last_read", 8'(want.last_read), 8'(last_read));
                check_field("done_res", 8'(want.done_res), 8'(done_res));
                check_field("status", 8'(want.status), 8'(status));
                beats_checked++;
            end
        end
    end

    // Stall the output in runs: mostly short, now and then long
    always @(posedge clk)
    begin
        if (stall_run <= 0)
        begin
            if (quiet)
            begin
                stall_hold = 1'b0;
                stall_run  = 1;
            end
            else
            begin
                stall_hold = ($urandom_range(0, 2) == 0);
                stall_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                         : $urandom_range(1, 3);
            end
        end
        stall_run--;
        out_stall <= stall_hold;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Every field random; callers override what matters
    function automatic bus_item_t random_item(logic [1:0] act);
        bus_item_t it;
        it.action         = act;
        it.device_address = 7'($urandom);
        it.write_count    = 8'($urandom);
        it.read_count     = 8'($urandom);
        it.data_byte      = 8'($urandom);
        it.ack_received   = 1'($urandom);
        it.received_byte  = 8'($urandom);
        return it;
    endfunction

    // Drive one beat, hold it until accepted, then predict and idle a while.
    // Called on a rising edge; returns on a rising edge.
    task automatic send_item(bus_item_t it);
        int gap;
        in_valid       <= 1'b1;
        action         <= it.action;
        device_address <= it.device_address;
        write_count    <= it.write_count;
        read_count     <= it.read_count;
        data_byte      <= it.data_byte;
        ack_received   <= it.ack_received;
        received_byte  <= it.received_byte;
        do
            @(posedge clk);
        while (in_stall);
        advance_sequencer(it);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_begin(logic [6:0] addr, logic [7:0] wc, logic [7:0] rc);
        bus_item_t it;
        it = random_item(ACT_BEGIN);
        it.device_address = addr;
        it.write_count    = wc;
        it.read_count     = rc;
        send_item(it);
    endtask

    task automatic send_write(logic [7:0] d);
        bus_item_t it;
        it = random_item(ACT_DATA);
        it.data_byte = d;
        send_item(it);
    endtask

    task automatic send_event(logic ack, logic [7:0] rx);
        bus_item_t it;
        it = random_item(ACT_EVENT);
        it.ack_received  = ack;
        it.received_byte = rx;
        send_item(it);
    endtask

    // Drop valid and hold off until every owed beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_due.size() != 0);
    endtask

    // Mostly the beat the current phase wants, with random content; some noise
    function automatic bus_item_t guided_item();
        bus_item_t it;
        int r;
        it = random_item(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 99) >= 12)
        begin
            case (seq_phase)
                SEQ_IDLE:      it.action = ACT_BEGIN;
                SEQ_NEED_DATA: it.action = ACT_DATA;
                SEQ_ADDR, SEQ_READDR:
                begin
                    it.action       = ACT_EVENT;
                    it.ack_received = ($urandom_range(0, 9) != 0);
                end
                default:       it.action = ACT_EVENT;
            endcase
        end
        // Keep most transactions short so that many of them fit in the run
        if (it.action == ACT_BEGIN && seq_phase == SEQ_IDLE)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                it.write_count = 8'($urandom_range(0, 3));
                it.read_count  = 8'($urandom_range(0, 3));
            end
            else if (r < 99)
            begin
                it.write_count = 8'($urandom_range(0, 12));
                it.read_count  = 8'($urandom_range(0, 12));
            end
            else
            begin
                it.write_count = 8'($urandom_range(0, 3));
                it.read_count  = 8'($urandom_range(13, 255));
            end
        end
        return it;
    endfunction

    task automatic drive_guided(int count, bit pause_at_idle);
        repeat (count)
        begin
            if (pause_at_idle && seq_phase == SEQ_IDLE)
                wait_drained();
            send_item(guided_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Beats the idle block must drop
    task automatic test_ignored_items();
        send_event(1'b1, 8'hff);
        send_write(8'hff);
        send_item(random_item(ACT_UNUSED));
    endtask

    // Both counts zero: address with the write bit, then stop
    task automatic test_empty_transaction();
        send_begin(7'h00, 8'd0, 8'd0);
        send_begin(7'h55, 8'd255, 8'd255);  // busy, dropped
        send_event(1'b1, 8'h00);
        send_begin(7'h7f, 8'd0, 8'd0);
        send_event(1'b0, 8'hff);            // address NACK
    endtask

    // Reads with no writes: read bit in the first address byte
    task automatic test_read_only();
        send_begin(7'h7f, 8'd0, 8'd2);
        send_event(1'b1, 8'h5a);
        send_event(1'b1, 8'hff);
        send_event(1'b0, 8'h00);
        send_begin(7'h01, 8'd0, 8'd1);
        send_event(1'b1, 8'h00);
        send_event(1'b1, 8'ha5);
    endtask

    // Writes, repeated start refused, then a plain write
    task automatic test_write_then_read();
        send_begin(7'h12, 8'd1, 8'd1);
        send_event(1'b1, 8'h00);
        send_event(1'b1, 8'h33);            // waiting for data, dropped
        send_write(8'hff);
        send_write(8'h77);                  // no data awaited, dropped
        send_event(1'b0, 8'h00);            // data NACK does not matter
        send_event(1'b0, 8'h00);            // NACK after repeated start
        send_begin(7'h2a, 8'd1, 8'd0);
        send_event(1'b1, 8'hff);
        send_write(8'h00);
        send_event(1'b1, 8'h00);
    endtask

    // Largest counts: one refused, one full read
    task automatic test_max_counts();
        send_begin(7'h3c, 8'd255, 8'd255);
        send_event(1'b0, 8'h00);
        send_begin(7'h40, 8'd0, 8'd255);
        send_event(1'b1, 8'h00);
        repeat (255) send_event(1'($urandom), 8'($urandom));
    endtask

    // Sender holds off until the block has caught up before each begin
    task automatic test_drain_pause();
        drive_guided(60, 1'b1);
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        quiet = 1'b1;
        drive_guided(80, 1'b0);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        drive_guided(425, 1'b0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_items();
        test_empty_transaction();
        test_read_only();
        test_write_then_read();
        test_max_counts();
        test_drain_pause();
        test_back_to_back();
        test_random_traffic();

        // Drain with the output free, then watch for stray beats
        quiet = 1'b1;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d input beats, %0d transactions begun, %0d result beats checked",
                 items_sent, transactions_begun, beats_checked);
        $display("directed corners, full-length reads, drained pauses and random stalls");
        if (errors == 0 && beats_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #6000000;
        $display("timeout with %0d result beats outstanding", beats_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
